// File: src/qrlp_pkg.sv
// ----------------------------------------------------------------------------
// Quoted record line parser package
// Shared event codes, parse phase codes, character constants, the result
// type and the saturating decimal digit helper.
// ----------------------------------------------------------------------------
package qrlp_pkg;

    // Widths of the item fields.
    localparam int BYTE_W  = 8;
    localparam int EVENT_W = 2;
    localparam int POP_W   = 31;
    localparam int PHASE_W = 3;

    // Result event codes.
    localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
    localparam logic [EVENT_W-1:0] EV_NAME   = 2'd1;
    localparam logic [EVENT_W-1:0] EV_ACCEPT = 2'd2;
    localparam logic [EVENT_W-1:0] EV_REJECT = 2'd3;

    // Parse phases.
    localparam logic [PHASE_W-1:0] PH_START     = 3'd0;
    localparam logic [PHASE_W-1:0] PH_RANK      = 3'd1;
    localparam logic [PHASE_W-1:0] PH_NAME_OPEN = 3'd2;
    localparam logic [PHASE_W-1:0] PH_NAME      = 3'd3;
    localparam logic [PHASE_W-1:0] PH_COMMA     = 3'd4;
    localparam logic [PHASE_W-1:0] PH_POP_OPEN  = 3'd5;
    localparam logic [PHASE_W-1:0] PH_POP       = 3'd6;

    // Characters of interest.
    localparam logic [BYTE_W-1:0] CH_DIGIT0 = 8'h30;
    localparam logic [BYTE_W-1:0] CH_DIGIT9 = 8'h39;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;

    // Saturation limits of the population value.
    localparam logic [POP_W-1:0] POP_MAX   = 31'd2147483647;
    localparam logic [POP_W-1:0] SAT_LIMIT = 31'd214748364;

    // One result item.
    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic [BYTE_W-1:0]  name_char;
        logic [POP_W-1:0]   population;
    } result_t;

    // Append one decimal digit, saturating at the largest population.
    function automatic logic [POP_W-1:0] add_digit(input logic [POP_W-1:0] acc,
                                                   input logic [3:0] digit);
        logic [POP_W-1:0] times_ten;
        times_ten = (acc << 3) + (acc << 1);
        if (acc > SAT_LIMIT || (acc == SAT_LIMIT && digit > 4'd7))
        begin
            return POP_MAX;
        end
        return times_ten + POP_W'(digit);
    endfunction

endpackage

// File: src/quoted_record_line_parser_unit.sv
// ----------------------------------------------------------------------------
// Quoted record line parser
// Checks text lines of the form rank,"name","population" or rank,"name",(
// one byte per item and reports name bytes and a verdict per line.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one byte of a line per item in text_byte, with
//   line_end high on the last byte of the line. Every input item produces
//   exactly one result item: event_res gives nothing, a name byte (in
//   name_char), an accepted record (with population) or a rejected line.
//   Results are registered, in the output register or, when it is held, in the
//   skid entry. Throughput is one item per cycle while in_stall is low, set
//   by the single parse state update that each byte makes.
//   Results go through an output register backed by one skid entry, so
//   in_stall is a registered signal. When the receiver holds out_stall, one
//   more item is taken into the skid entry and then in_stall rises until
//   the output drains.
//   Reset clears the parse state to the start of a line and empties the
//   output register and skid entry.
// ----------------------------------------------------------------------------
module quoted_record_line_parser_unit
    import qrlp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [BYTE_W-1:0]  text_byte,
    input  logic               line_end,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [EVENT_W-1:0] event_res,
    output logic [BYTE_W-1:0]  name_char,
    output logic [POP_W-1:0]   population
);

    logic    in_fire;
    logic    out_fire;
    result_t new_res;
    logic    out_valid_reg;
    result_t out_res_reg;
    logic    skid_valid_reg;
    result_t skid_res_reg;

    assign in_stall = skid_valid_reg;
    assign in_fire  = in_valid && !skid_valid_reg;
    assign out_fire = out_valid_reg && !out_stall;

    qrlp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (in_fire),
        .text_byte (text_byte),
        .line_end  (line_end),
        .result    (new_res)
    );

    // Output register and skid entry control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_fire)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload moves without reset.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_res_reg <= skid_res_reg;
            end
        end
        else if (in_fire)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_res_reg <= new_res;
            end
            else
            begin
                out_res_reg <= new_res;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_res  = out_res_reg.event_res;
    assign name_char  = out_res_reg.name_char;
    assign population = out_res_reg.population;

endmodule

// File: src/qrlp_parser.sv
// ----------------------------------------------------------------------------
// Quoted record line parser state machine
// Holds the per-line parse state and works out the result of one byte.
// ----------------------------------------------------------------------------
module qrlp_parser
    import qrlp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  logic [BYTE_W-1:0] text_byte,
    input  logic              line_end,
    output result_t           result
);

    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic [POP_W-1:0]   acc_reg;
    logic [POP_W-1:0]   acc_next;
    logic               finished_reg;
    logic               finished_next;
    logic               is_digit;
    logic [BYTE_W-1:0]  digit_diff;
    logic [EVENT_W-1:0] ev;
    logic [BYTE_W-1:0]  ch;
    logic [POP_W-1:0]   pop;

    assign is_digit   = (text_byte inside {[CH_DIGIT0:CH_DIGIT9]});
    assign digit_diff = text_byte - CH_DIGIT0;

    // Next state and result of the byte at the input.
    always_comb
    begin
        phase_next    = phase_reg;
        acc_next      = acc_reg;
        finished_next = finished_reg;
        ev            = EV_NONE;
        ch            = '0;
        pop           = '0;

        if (finished_reg)
        begin
            // Verdict already given: skip bytes until the line ends.
            if (line_end)
            begin
                phase_next    = PH_START;
                acc_next      = '0;
                finished_next = 1'b0;
            end
        end
        else
        begin
            case (phase_reg)
                PH_START:
                begin
                    if (is_digit) phase_next = PH_RANK;
                    else ev = EV_REJECT;
                end
                PH_RANK:
                begin
                    if (is_digit) phase_next = PH_RANK;
                    else if (text_byte == CH_COMMA) phase_next = PH_NAME_OPEN;
                    else ev = EV_REJECT;
                end
                PH_NAME_OPEN:
                begin
                    if (text_byte == CH_QUOTE) phase_next = PH_NAME;
                    else ev = EV_REJECT;
                end
                PH_NAME:
                begin
                    if (text_byte == CH_QUOTE)
                    begin
                        phase_next = PH_COMMA;
                    end
                    else
                    begin
                        ev = EV_NAME;
                        ch = text_byte;
                    end
                end
                PH_COMMA:
                begin
                    if (text_byte == CH_COMMA) phase_next = PH_POP_OPEN;
                    else ev = EV_REJECT;
                end
                PH_POP_OPEN:
                begin
                    if (text_byte == CH_QUOTE)
                    begin
                        phase_next = PH_POP;
                        acc_next   = '0;
                    end
                    else if (text_byte == CH_LPAREN)
                    begin
                        ev = EV_ACCEPT;
                    end
                    else
                    begin
                        ev = EV_REJECT;
                    end
                end
                PH_POP:
                begin
                    if (is_digit)
                    begin
                        acc_next = add_digit(acc_reg, digit_diff[3:0]);
                    end
                    else if (text_byte == CH_COMMA)
                    begin
                        acc_next = acc_reg;
                    end
                    else if (text_byte == CH_QUOTE)
                    begin
                        ev  = EV_ACCEPT;
                        pop = acc_reg;
                    end
                    else
                    begin
                        ev = EV_REJECT;
                    end
                end
                default:
                begin
                    ev = EV_REJECT;
                end
            endcase

            // A line that ends without a verdict is rejected on its last byte.
            if (line_end && ev != EV_ACCEPT && ev != EV_REJECT)
            begin
                ev = EV_REJECT;
                ch = '0;
            end

            // After a verdict, clear at once or wait for the end of the line.
            if (ev == EV_ACCEPT || ev == EV_REJECT)
            begin
                if (line_end)
                begin
                    phase_next    = PH_START;
                    acc_next      = '0;
                    finished_next = 1'b0;
                end
                else
                begin
                    finished_next = 1'b1;
                end
            end
        end
    end

    assign result.event_res  = ev;
    assign result.name_char  = ch;
    assign result.population = pop;

    // Parse state advances only on an accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_START;
            acc_reg      <= '0;
            finished_reg <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg    <= phase_next;
            acc_reg      <= acc_next;
            finished_reg <= finished_next;
        end
    end

endmodule

// File: src/qrlp_checker.sv
// ----------------------------------------------------------------------------
// Quoted record line parser checker
// Port level assertions on result timing and result field contents.
// ----------------------------------------------------------------------------
module qrlp_checker
    import qrlp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [EVENT_W-1:0] event_res,
    input logic [BYTE_W-1:0]  name_char,
    input logic [POP_W-1:0]   population
);

    // An accepted item always has a result waiting in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("no result after an accepted item");

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    // The name byte is zero unless the event is a name character.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res != EV_NAME |-> name_char == '0)
        else $error("name byte set on a non-name event");

    // The population is zero unless the record is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res != EV_ACCEPT |-> population == '0)
        else $error("population set on a non-accept event");

endmodule

bind quoted_record_line_parser_unit qrlp_checker u_qrlp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_res  (event_res),
    .name_char  (name_char),
    .population (population)
);
